/* design/tmtc_pkg.sv */
// tmtc_pkg: shared types, constants and hash functions of the tick transition counter
// used by every file of the block but tmtc_ram; depends on nothing

package tmtc_pkg;

    localparam int HISTORY_DEPTH_DEF = 2;
    localparam int COUNTER_BITS_DEF  = 32;
    localparam int BUCKET_BITS       = 5;
    localparam int PAIR_BITS         = 2 * BUCKET_BITS;
    localparam int STAMP_BITS        = 48;
    localparam int COEF_BITS         = 24;
    localparam int EXPO_BITS         = 8;
    localparam int INDEX_OUT_BITS    = 20;
    localparam int COUNT_OUT_BITS    = 32;
    localparam int S_TDATA_BITS      = 104;
    localparam int M_TDATA_BITS      = 64;

    typedef enum logic
    {
        CMD_TICK = 1'b0,
        CMD_READ = 1'b1
    } command_t;

    typedef enum logic [1:0]
    {
        STATUS_COUNTED  = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_READ     = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_HASH,
        ST_LOOKUP,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic clear_en;
        logic load_in;
        logic reject;
        logic check;
        logic push;
        logic lookup;
        logic update;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic is_read;
        logic mismatch;
        logic clear_last;
    } dp_status_t;

    // bit length of the stamp delta, zero when backwards or 32 bits or more
    function automatic logic [BUCKET_BITS-1:0] time_bucket(
        input logic [STAMP_BITS-1:0] delta,
        input logic                  backwards
    );
        logic [BUCKET_BITS-1:0] n;
        n = '0;
        for (int i = 0; i < 31; i++)
        begin
            if (delta[i])
            begin
                n = BUCKET_BITS'(i + 1);
            end
        end
        if (backwards || (|delta[STAMP_BITS-1:31]))
        begin
            n = '0;
        end
        return n;
    endfunction

    // 9*(digits-1) plus leading digit, zero when negative or not below 32
    function automatic logic [BUCKET_BITS-1:0] value_bucket(
        input logic                 neg,
        input logic [COEF_BITS-1:0] coef
    );
        logic [1:0]             digits;
        logic [COEF_BITS-1:0]   pow;
        logic [3:0]             lead;
        logic [5:0]             x;
        logic [BUCKET_BITS-1:0] res;
        digits = 2'd0;
        pow    = COEF_BITS'(1);
        lead   = 4'd0;
        if (coef >= COEF_BITS'(1000))
        begin
            digits = 2'd3;
            pow    = COEF_BITS'(1000);
        end
        else if (coef >= COEF_BITS'(100))
        begin
            digits = 2'd2;
            pow    = COEF_BITS'(100);
        end
        else if (coef >= COEF_BITS'(10))
        begin
            digits = 2'd1;
            pow    = COEF_BITS'(10);
        end
        for (int k = 1; k < 10; k++)
        begin
            if (coef >= COEF_BITS'(k * int'(pow)))
            begin
                lead = lead + 4'd1;
            end
        end
        x   = 6'({digits, 3'b000}) + 6'(digits) + 6'(lead);
        res = x[BUCKET_BITS-1:0];
        if (neg || (coef >= COEF_BITS'(10000)) || x[5])
        begin
            res = '0;
        end
        return res;
    endfunction

endpackage

/* design/tick_markov_transition_counter.sv */
// tick_markov_transition_counter: top level, stream ports and field packing
// depends on tmtc_pkg, tmtc_ctrl and tmtc_datapath
//
// usage
// input stream s_axis: tuser is the command (tick or counter read), tdata the tick fields
// and the read index; output stream m_axis: tuser is the status, tdata the buckets,
// the counter index and the count
// a tick hashes its stamp delta and value to two buckets, pushes the pair into the
// history shift line and increments the saturating counter the history addresses
// a tick whose exponent differs from a nonzero stored quantum is rejected and changes nothing
// the sequencer and the single counter memory port take a transaction only once the last
// is through: a counted tick passes check, hash, lookup, update and done, a read check,
// update and done, a rejected tick check and done; its result becomes valid in the same
// cycle that the block is idle again; the output register holds a finished result while
// the next transaction is accepted; if the receiver stalls longer, the block waits with
// its next result until taken; after reset the counter memory is cleared one entry per
// cycle, 2^(10*HISTORY_DEPTH) entries (1048576 at default depth), with s_axis_tready low

module tick_markov_transition_counter #(
    parameter int HISTORY_DEPTH = tmtc_pkg::HISTORY_DEPTH_DEF,
    parameter int COUNTER_BITS  = tmtc_pkg::COUNTER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // stamp[47:0], sign[48], coefficient[72:49], exponent[80:73], read index[100:81]
    input  logic [tmtc_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
    // command[0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // time bucket[4:0], value bucket[9:5], chain index[29:10], count[61:30]
    output logic [tmtc_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]                        m_axis_tuser
);

    tmtc_pkg::ctrl_cmd_t                       cmd;
    tmtc_pkg::dp_status_t                      st;
    logic [tmtc_pkg::BUCKET_BITS-1:0]          time_bucket;
    logic [tmtc_pkg::BUCKET_BITS-1:0]          value_bucket;
    logic [tmtc_pkg::INDEX_OUT_BITS-1:0]       chain_index;
    logic [tmtc_pkg::COUNT_OUT_BITS-1:0]       count;

    tmtc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .st            (st),
        .cmd           (cmd)
    );

    tmtc_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .in_command       (s_axis_tuser),
        .in_stamp         (s_axis_tdata[47:0]),
        .in_neg           (s_axis_tdata[48]),
        .in_coef          (s_axis_tdata[72:49]),
        .in_expo          (s_axis_tdata[80:73]),
        .in_read_index    (s_axis_tdata[100:81]),
        .out_status       (m_axis_tuser),
        .out_time_bucket  (time_bucket),
        .out_value_bucket (value_bucket),
        .out_chain_index  (chain_index),
        .out_count        (count)
    );

    assign m_axis_tdata = {2'b00, count, chain_index, value_bucket, time_bucket};

endmodule

/* design/tmtc_ram.sv */
// tmtc_ram: generic single-write, single-read memory with registered read data
// no dependencies

module tmtc_ram #(
    parameter int WIDTH     = 32,
    parameter int ADDR_BITS = 20
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_BITS];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/tmtc_ctrl.sv */
// tmtc_ctrl: sequencing state machine and output valid of the transition counter
// depends on tmtc_pkg

module tmtc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  tmtc_pkg::dp_status_t st,
    output tmtc_pkg::ctrl_cmd_t  cmd
);

    tmtc_pkg::state_t state_reg;
    tmtc_pkg::state_t state_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tmtc_pkg::ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_axis_tready;
        case (state_reg)
            tmtc_pkg::ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (st.clear_last)
                begin
                    state_next = tmtc_pkg::ST_IDLE;
                end
            end
            tmtc_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = tmtc_pkg::ST_CHECK;
                end
            end
            tmtc_pkg::ST_CHECK:
            begin
                if (st.is_read)
                begin
                    cmd.lookup = 1'b1;
                    state_next = tmtc_pkg::ST_UPDATE;
                end
                else if (st.mismatch)
                begin
                    cmd.reject = 1'b1;
                    state_next = tmtc_pkg::ST_DONE;
                end
                else
                begin
                    cmd.check  = 1'b1;
                    state_next = tmtc_pkg::ST_HASH;
                end
            end
            tmtc_pkg::ST_HASH:
            begin
                cmd.push   = 1'b1;
                state_next = tmtc_pkg::ST_LOOKUP;
            end
            tmtc_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = tmtc_pkg::ST_UPDATE;
            end
            tmtc_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = tmtc_pkg::ST_DONE;
            end
            tmtc_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = tmtc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmtc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = m_tvalid_reg;

endmodule

/* design/tmtc_datapath.sv */
// tmtc_datapath: hashing, history shift line, counter memory and result registers
// depends on tmtc_pkg and tmtc_ram

module tmtc_datapath #(
    parameter int HISTORY_DEPTH = tmtc_pkg::HISTORY_DEPTH_DEF,
    parameter int COUNTER_BITS  = tmtc_pkg::COUNTER_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  tmtc_pkg::ctrl_cmd_t                     cmd,
    output tmtc_pkg::dp_status_t                    st,
    input  logic                                    in_command,
    input  logic [tmtc_pkg::STAMP_BITS-1:0]         in_stamp,
    input  logic                                    in_neg,
    input  logic [tmtc_pkg::COEF_BITS-1:0]          in_coef,
    input  logic signed [tmtc_pkg::EXPO_BITS-1:0]   in_expo,
    input  logic [tmtc_pkg::INDEX_OUT_BITS-1:0]     in_read_index,
    output logic [1:0]                              out_status,
    output logic [tmtc_pkg::BUCKET_BITS-1:0]        out_time_bucket,
    output logic [tmtc_pkg::BUCKET_BITS-1:0]        out_value_bucket,
    output logic [tmtc_pkg::INDEX_OUT_BITS-1:0]     out_chain_index,
    output logic [tmtc_pkg::COUNT_OUT_BITS-1:0]     out_count
);

    localparam int INDEX_BITS = tmtc_pkg::PAIR_BITS * HISTORY_DEPTH;
    localparam int IDX_EXT    = (INDEX_BITS > tmtc_pkg::INDEX_OUT_BITS) ?
                                INDEX_BITS : tmtc_pkg::INDEX_OUT_BITS;
    localparam int CNT_EXT    = (COUNTER_BITS > tmtc_pkg::COUNT_OUT_BITS) ?
                                COUNTER_BITS : tmtc_pkg::COUNT_OUT_BITS;
    localparam int BB         = tmtc_pkg::BUCKET_BITS;

    // input capture
    logic                                  is_read_reg;
    logic [tmtc_pkg::STAMP_BITS-1:0]       stamp_reg;
    logic                                  neg_reg;
    logic [tmtc_pkg::COEF_BITS-1:0]        coef_reg;
    logic signed [tmtc_pkg::EXPO_BITS-1:0] expo_reg;
    logic [tmtc_pkg::INDEX_OUT_BITS-1:0]   read_index_reg;

    // block state
    logic [tmtc_pkg::STAMP_BITS-1:0]       last_stamp_reg;
    logic signed [tmtc_pkg::EXPO_BITS-1:0] quantum_reg;
    logic [tmtc_pkg::PAIR_BITS-1:0]        hist_reg [HISTORY_DEPTH];
    logic [INDEX_BITS-1:0]                 clear_addr_reg;

    // hash stage
    logic [tmtc_pkg::STAMP_BITS-1:0]       delta_reg;
    logic                                  back_reg;
    logic [BB-1:0]                         vb_reg;
    logic [BB-1:0]                         tb_reg;

    // result and output
    logic [1:0]                            res_status_reg;
    logic [BB-1:0]                         res_tb_reg;
    logic [BB-1:0]                         res_vb_reg;
    logic [tmtc_pkg::INDEX_OUT_BITS-1:0]   res_chain_reg;
    logic [tmtc_pkg::COUNT_OUT_BITS-1:0]   res_count_reg;
    logic [1:0]                            o_status_reg;
    logic [BB-1:0]                         o_tb_reg;
    logic [BB-1:0]                         o_vb_reg;
    logic [tmtc_pkg::INDEX_OUT_BITS-1:0]   o_chain_reg;
    logic [tmtc_pkg::COUNT_OUT_BITS-1:0]   o_count_reg;

    logic [BB-1:0]                         tb_calc;
    logic [INDEX_BITS-1:0]                 key;
    logic [INDEX_BITS-1:0]                 addr;
    logic [IDX_EXT-1:0]                    addr_ext;
    logic [COUNTER_BITS-1:0]               rdata;
    logic [COUNTER_BITS-1:0]               cnt_inc;
    logic [CNT_EXT-1:0]                    cnt_ext;
    logic [CNT_EXT-1:0]                    rd_ext;
    logic                                  ram_we;
    logic [INDEX_BITS-1:0]                 ram_waddr;
    logic [COUNTER_BITS-1:0]               ram_wdata;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            is_read_reg    <= in_command;
            stamp_reg      <= in_stamp;
            neg_reg        <= in_neg;
            coef_reg       <= in_coef;
            expo_reg       <= in_expo;
            read_index_reg <= in_read_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg <= '0;
            quantum_reg    <= '0;
            clear_addr_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clear_addr_reg <= clear_addr_reg + INDEX_BITS'(1);
            end
            if (cmd.check)
            begin
                quantum_reg <= expo_reg;
            end
            if (cmd.push)
            begin
                last_stamp_reg <= stamp_reg;
                for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                begin
                    hist_reg[i] <= hist_reg[i + 1];
                end
                hist_reg[HISTORY_DEPTH - 1] <= {tb_calc, vb_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            delta_reg <= stamp_reg - last_stamp_reg;
            back_reg  <= stamp_reg < last_stamp_reg;
            vb_reg    <= tmtc_pkg::value_bucket(neg_reg, coef_reg);
        end
        if (cmd.push)
        begin
            tb_reg <= tb_calc;
        end
    end

    assign tb_calc = tmtc_pkg::time_bucket(delta_reg, back_reg);

    // oldest pair in the top bits
    always_comb
    begin
        key = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            key[(HISTORY_DEPTH - 1 - i) * tmtc_pkg::PAIR_BITS +: tmtc_pkg::PAIR_BITS] =
                hist_reg[i];
        end
    end

    assign addr     = is_read_reg ? INDEX_BITS'(IDX_EXT'(read_index_reg)) : key;
    assign addr_ext = IDX_EXT'(addr);

    assign cnt_inc = (&rdata) ? rdata : rdata + COUNTER_BITS'(1);
    assign cnt_ext = CNT_EXT'(cnt_inc);
    assign rd_ext  = CNT_EXT'(rdata);

    assign ram_we    = cmd.clear_en || (cmd.update && !is_read_reg);
    assign ram_waddr = cmd.clear_en ? clear_addr_reg : addr;
    assign ram_wdata = cmd.clear_en ? '0 : cnt_inc;

    tmtc_ram #(
        .WIDTH     (COUNTER_BITS),
        .ADDR_BITS (INDEX_BITS)
    ) u_counters (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.lookup),
        .raddr (addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.reject)
        begin
            res_status_reg <= tmtc_pkg::STATUS_REJECTED;
            res_tb_reg     <= '0;
            res_vb_reg     <= '0;
            res_chain_reg  <= '0;
            res_count_reg  <= '0;
        end
        else if (cmd.update)
        begin
            res_chain_reg <= addr_ext[tmtc_pkg::INDEX_OUT_BITS-1:0];
            if (is_read_reg)
            begin
                res_status_reg <= tmtc_pkg::STATUS_READ;
                res_tb_reg     <= '0;
                res_vb_reg     <= '0;
                res_count_reg  <= rd_ext[tmtc_pkg::COUNT_OUT_BITS-1:0];
            end
            else
            begin
                res_status_reg <= tmtc_pkg::STATUS_COUNTED;
                res_tb_reg     <= tb_reg;
                res_vb_reg     <= vb_reg;
                res_count_reg  <= cnt_ext[tmtc_pkg::COUNT_OUT_BITS-1:0];
            end
        end
        if (cmd.out_load)
        begin
            o_status_reg <= res_status_reg;
            o_tb_reg     <= res_tb_reg;
            o_vb_reg     <= res_vb_reg;
            o_chain_reg  <= res_chain_reg;
            o_count_reg  <= res_count_reg;
        end
    end

    assign st.is_read    = is_read_reg;
    assign st.mismatch   = (quantum_reg != '0) && (expo_reg != quantum_reg);
    assign st.clear_last = &clear_addr_reg;

    assign out_status       = o_status_reg;
    assign out_time_bucket  = o_tb_reg;
    assign out_value_bucket = o_vb_reg;
    assign out_chain_index  = o_chain_reg;
    assign out_count        = o_count_reg;

endmodule

/* tb/tb_tick_markov_transition_counter.sv */
// tb_tick_markov_transition_counter: self-checking testbench of the tick transition counter
// predicts every result from its own copy of the hash, history and counter store state
// depends on tmtc_pkg and tick_markov_transition_counter

module tb_tick_markov_transition_counter;

    import tmtc_pkg::*;

    localparam int KEY_BITS       = PAIR_BITS * HISTORY_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 3200000;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int TAIL_CYCLES    = 20;
    localparam logic signed [EXPO_BITS-1:0] QUANTUM = -8'sd101;

    typedef struct
    {
        status_t                    status;
        logic [BUCKET_BITS-1:0]     time_bkt;
        logic [BUCKET_BITS-1:0]     value_bkt;
        logic [INDEX_OUT_BITS-1:0]  chain;
        logic [COUNT_OUT_BITS-1:0]  count;
    } tick_result_t;

    class transition_tracker;
        logic [STAMP_BITS-1:0]        last_stamp;
        logic signed [EXPO_BITS-1:0]  quantum;
        logic [PAIR_BITS-1:0]         history [HISTORY_DEPTH_DEF];
        int                           ring_pos;
        int unsigned                  counters [logic [KEY_BITS-1:0]];
        logic [KEY_BITS-1:0]          touched [$];
        tick_result_t                 pending_results [$];
        int                           errors;

        function new();
            last_stamp = '0;
            quantum    = '0;
            ring_pos   = 0;
            errors     = 0;
            foreach (history[i])
            begin
                history[i] = '0;
            end
        endfunction

        function logic [BUCKET_BITS-1:0] stamp_bucket(logic [STAMP_BITS-1:0] now);
            logic [STAMP_BITS-1:0] d;
            int n;
            n = 0;
            if (now < last_stamp)
            begin
                return '0;
            end
            d = now - last_stamp;
            while (d != 0)
            begin
                n++;
                d = d >> 1;
            end
            return (n < 32) ? BUCKET_BITS'(n) : '0;
        endfunction

        function logic [BUCKET_BITS-1:0] coef_bucket(logic neg, logic [COEF_BITS-1:0] coef);
            int unsigned lead;
            int unsigned digits;
            int unsigned x;
            if (neg || coef == 0)
            begin
                return '0;
            end
            lead   = coef;
            digits = 0;
            while (lead >= 10)
            begin
                lead = lead / 10;
                digits++;
            end
            x = 9 * digits + lead;
            return (x < 32) ? BUCKET_BITS'(x) : '0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function logic [KEY_BITS-1:0] recent_key();
            if (touched.size() == 0)
            begin
                return KEY_BITS'($urandom);
            end
            return touched[$urandom_range(0, touched.size() - 1)];
        endfunction

        function void note_transaction(logic cmd, logic [S_TDATA_BITS-1:0] data);
            logic [STAMP_BITS-1:0]        stamp;
            logic                         neg;
            logic [COEF_BITS-1:0]         coef;
            logic signed [EXPO_BITS-1:0]  expo;
            logic [KEY_BITS-1:0]          key;
            int unsigned                  cnt;
            tick_result_t                 r;
            stamp = data[47:0];
            neg   = data[48];
            coef  = data[72:49];
            expo  = data[80:73];
            r.status    = STATUS_COUNTED;
            r.time_bkt  = '0;
            r.value_bkt = '0;
            r.chain     = '0;
            r.count     = '0;
            if (cmd == CMD_READ)
            begin
                key      = data[100:81];
                r.status = STATUS_READ;
                r.chain  = key;
                r.count  = counters.exists(key) ? counters[key] : 0;
            end
            else if (quantum != 0 && expo != quantum)
            begin
                r.status = STATUS_REJECTED;
            end
            else
            begin
                quantum     = expo;
                r.time_bkt  = stamp_bucket(stamp);
                r.value_bkt = coef_bucket(neg, coef);
                history[ring_pos] = {r.time_bkt, r.value_bkt};
                ring_pos = (ring_pos + 1) % HISTORY_DEPTH_DEF;
                key = '0;
                for (int i = 0; i < HISTORY_DEPTH_DEF; i++)
                begin
                    key = (key << PAIR_BITS) | history[(ring_pos + i) % HISTORY_DEPTH_DEF];
                end
                cnt = counters.exists(key) ? counters[key] : 0;
                if (cnt != 32'hFFFF_FFFF)
                begin
                    cnt++;
                end
                counters[key] = cnt;
                touched.push_back(key);
                if (touched.size() > 64)
                begin
                    void'(touched.pop_front());
                end
                last_stamp = stamp;
                r.chain    = key;
                r.count    = cnt;
            end
            pending_results.push_back(r);
        endfunction

        task report(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 50)
            begin
                $display("tb: mismatch on %s, expected %0h, got %0h", field, want, got);
            end
        endtask

        task check_transaction(logic [1:0] user, logic [M_TDATA_BITS-1:0] data);
            tick_result_t r;
            if (pending_results.size() == 0)
            begin
                report("unexpected result status", 0, user);
                return;
            end
            r = pending_results.pop_front();
            if (user !== r.status)
            begin
                report("status", r.status, user);
            end
            if (data[4:0] !== r.time_bkt)
            begin
                report("time bucket", r.time_bkt, data[4:0]);
            end
            if (data[9:5] !== r.value_bkt)
            begin
                report("value bucket", r.value_bkt, data[9:5]);
            end
            if (data[29:10] !== r.chain)
            begin
                report("chain index", r.chain, data[29:10]);
            end
            if (data[61:30] !== r.count)
            begin
                report("count", r.count, data[61:30]);
            end
        endtask
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata = '0;
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_axis_tdata;
    logic [1:0]              m_axis_tuser;

    transition_tracker tracker = new();
    int burst_left = 0;
    int quiet_cycles = 0;
    int rcv_mode = 0;
    int rcv_left = 0;

    tick_markov_transition_counter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic [S_TDATA_BITS-1:0] pack_item(
        logic [STAMP_BITS-1:0] stamp,
        logic                  neg,
        logic [COEF_BITS-1:0]  coef,
        logic [EXPO_BITS-1:0]  expo,
        logic [19:0]           idx
    );
        return {3'b000, idx, expo, coef, neg, stamp};
    endfunction

    function automatic logic [STAMP_BITS-1:0] rand_stamp48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [S_TDATA_BITS-1:0] rand_tick(logic [EXPO_BITS-1:0] expo);
        logic [STAMP_BITS-1:0] stamp;
        logic [COEF_BITS-1:0]  coef;
        int sel;
        int digits;
        stamp = tracker.last_stamp;
        sel = $urandom_range(0, 99);
        if (sel < 10)
        begin
            stamp = tracker.last_stamp;
        end
        else if (sel < 15)
        begin
            stamp = (tracker.last_stamp == 0) ? '0 : rand_stamp48() % tracker.last_stamp;
        end
        else if (sel < 20)
        begin
            stamp = rand_stamp48();
        end
        else if (sel < 75)
        begin
            stamp = tracker.last_stamp + STAMP_BITS'($urandom_range(1, 15));
        end
        else
        begin
            stamp = tracker.last_stamp + STAMP_BITS'($urandom >> $urandom_range(0, 31)) + 1;
        end
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            coef = '0;
        end
        else if (sel < 60)
        begin
            coef = COEF_BITS'($urandom_range(1, 19));
        end
        else
        begin
            digits = $urandom_range(1, 7);
            coef = COEF_BITS'($urandom_range(10 ** (digits - 1), 10 ** digits - 1));
        end
        return pack_item(stamp, ($urandom_range(0, 4) == 0), coef, expo, 20'($urandom));
    endfunction

    task automatic send_item(input logic cmd, input logic [S_TDATA_BITS-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        tracker.note_transaction(cmd, data);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_read(input logic [19:0] idx);
        send_item(CMD_READ, pack_item(rand_stamp48(), 1'($urandom),
                                      COEF_BITS'($urandom_range(0, 9999999)),
                                      EXPO_BITS'($urandom), idx));
    endtask

    // receiver: long ready stretches, random toggling and stalls of assorted length
    always @(negedge clk)
    begin
        if (rcv_left == 0)
        begin
            rcv_mode = $urandom_range(0, 3);
            case (rcv_mode)
                0: rcv_left = $urandom_range(20, 80);
                1: rcv_left = $urandom_range(1, 12);
                2: rcv_left = $urandom_range(10, 40);
                default: rcv_left = $urandom_range(1, 3);
            endcase
        end
        rcv_left--;
        m_axis_tready <= (rcv_mode == 0) ? 1'b1 : (rcv_mode == 2) ? 1'($urandom) : 1'b0;
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            tracker.check_transaction(m_axis_tuser, m_axis_tdata);
        end
    end

    // watchdog on cycles without any transaction; the counter clear after reset is the longest
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [EXPO_BITS-1:0] expo;
        int sel;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: store empty, hash corners, quantum set and rejects, repeated pairs
        send_read('0);
        send_read(20'hFFFFF);
        send_item(CMD_TICK, pack_item('0, 1'b0, '0, '0, 20'hFFFFF));
        send_item(CMD_TICK, pack_item(48'd1, 1'b0, 24'd9, '0, '0));
        send_item(CMD_TICK, pack_item(48'd1, 1'b1, 24'd5, '0, '0));
        send_item(CMD_TICK, pack_item(48'd0, 1'b0, 24'd10, '0, '0));
        send_item(CMD_TICK, pack_item(48'h7FFF_FFFF, 1'b0, 24'd4999, '0, '0));
        send_item(CMD_TICK, pack_item(48'hFFFF_FFFF, 1'b0, 24'd5000, '0, '0));
        send_item(CMD_TICK, pack_item(48'hFFFF_FFFF_FFFF, 1'b0, 24'd9999999, '0, '0));
        send_item(CMD_TICK, pack_item(48'hFFFF_FFFF_FFFF, 1'b0, 24'd1000, QUANTUM, '0));
        send_item(CMD_TICK, pack_item(48'd5, 1'b0, 24'd7, 8'sd90, '0));
        send_item(CMD_TICK, pack_item(48'd6, 1'b0, 24'd7, '0, '0));
        send_item(CMD_TICK, pack_item('0, 1'b0, 24'd99, QUANTUM, '0));
        repeat (3)
        begin
            send_item(CMD_TICK, pack_item(tracker.last_stamp + 1, 1'b0, 24'd9, QUANTUM, '0));
        end
        send_read(tracker.recent_key());
        send_item(CMD_READ, pack_item('1, 1'b1, 24'hFFFFFF, 8'hFF, tracker.recent_key()));
        send_item(CMD_TICK, pack_item(tracker.last_stamp + 48'h10_0000, 1'b1, 24'd1234567,
                                      QUANTUM, 20'hFFFFF));
        wait_results_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                send_item(CMD_TICK, rand_tick(tracker.quantum));
            end
            else if (sel < 85)
            begin
                send_read(($urandom_range(0, 3) != 0) ? tracker.recent_key() : 20'($urandom));
            end
            else
            begin
                expo = (sel < 95) ? EXPO_BITS'($urandom_range(0, 191) - 101) : '0;
                send_item(CMD_TICK, rand_tick(expo));
            end
            if (n % 300 == 299)
            begin
                wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
